// ===== rtl/fpd_pkg.sv =====
`timescale 1ns / 1ps

package fpd_pkg;

  // width of every field on the channels
  localparam int FIELD_BITS = 32;

  // default format: q16.16 on a 32-bit word
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // operand status from the preparation stage
  typedef struct packed {
    logic neg;       // result sign differs from positive
    logic div_zero;  // divisor is zero, result saturates
  } fpd_flags_t;

endpackage

// ===== rtl/fpd_in_if.sv =====
`timescale 1ns / 1ps

interface fpd_in_if import fpd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] dividend;
  logic signed [FIELD_BITS-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// ===== rtl/fpd_out_if.sv =====
`timescale 1ns / 1ps

interface fpd_out_if import fpd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

// ===== rtl/fpd_operand_prep.sv =====
`timescale 1ns / 1ps

module fpd_operand_prep import fpd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0] word_a,
  input  logic [WORD_BITS-1:0] word_b,
  output logic [WORD_BITS-1:0] mag_a,
  output logic [WORD_BITS-1:0] mag_b,
  output fpd_flags_t           flags
);

  // two's complement magnitudes; the most negative word maps to 2^(w-1) unsigned
  assign mag_a = word_a[WORD_BITS-1] ? (~word_a + 1'b1) : word_a;
  assign mag_b = word_b[WORD_BITS-1] ? (~word_b + 1'b1) : word_b;

  // sign of the result and zero divisor detection
  assign flags.neg      = word_a[WORD_BITS-1] ^ word_b[WORD_BITS-1];
  assign flags.div_zero = (word_b == '0);

endmodule

// ===== rtl/fpd_step_unit.sv =====
`timescale 1ns / 1ps

module fpd_step_unit import fpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic [WORD_BITS+FRAC_BITS-1:0] prod,
  input  logic [WORD_BITS+FRAC_BITS-1:0] shd,
  input  logic [WORD_BITS-1:0]           mag_a,
  output logic [WORD_BITS+FRAC_BITS-1:0] sum,
  output logic                           take
);

  localparam int PW = WORD_BITS + FRAC_BITS;

  logic [PW:0]        sum_full;
  logic [WORD_BITS:0] scaled;

  // product of the trial value and divisor, built from the running product
  assign sum_full = {1'b0, prod} + {1'b0, shd};
  assign scaled   = sum_full[PW:FRAC_BITS];

  // keep the trial bit when the truncated product stays at or below the dividend
  assign take = (scaled <= {1'b0, mag_a});
  assign sum  = sum_full[PW-1:0];

endmodule

// ===== rtl/fixed_point_divider_top.sv =====
`timescale 1ns / 1ps

// Signed fixed-point divider (FRAC_BITS fraction bits in a WORD_BITS-bit word,
// sign-extended to the 32-bit fields). One operand beat gives one quotient beat;
// a zero divisor gives the largest positive value and a quotient too large to
// represent saturates in magnitude. Items are handled one at a time, with
// operand ready low while a division runs. An item is loaded, then shifted
// right once per step until the divisor magnitude is at most one
// (0 to WORD_BITS-1-FRAC_BITS shifts), the search is set up, WORD_BITS-1 bit
// trials run on the shared add-compare unit and the quotient is handed to
// the output register; a zero divisor goes from the load straight to the
// hand-over. The output register lets the next operands be taken while a
// quotient waits.

module fixed_point_divider_top import fpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fpd_in_if.sink    operands,
  fpd_out_if.source result
);

  localparam int PW = WORD_BITS + FRAC_BITS;
  localparam logic [PW-1:0] UNIT = PW'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [WORD_BITS-1:0]   mag_a;
  logic [WORD_BITS-1:0]   mag_b;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          shd;
  logic [WORD_BITS-2:0]   bitm;
  logic [WORD_BITS-2:0]   sol;
  logic                   neg;
  logic                   res_valid;
  logic [FIELD_BITS-1:0]  res_quotient;

  logic [WORD_BITS-1:0]   prep_mag_a;
  logic [WORD_BITS-1:0]   prep_mag_b;
  fpd_flags_t             prep_flags;
  logic [PW-1:0]          step_sum;
  logic                   step_take;
  logic signed [WORD_BITS-1:0] signed_q;
  logic                   res_free;

  // operand magnitudes and sign
  fpd_operand_prep #(
    .WORD_BITS (WORD_BITS)
  ) u_prep (
    .word_a (operands.dividend[WORD_BITS-1:0]),
    .word_b (operands.divisor[WORD_BITS-1:0]),
    .mag_a  (prep_mag_a),
    .mag_b  (prep_mag_b),
    .flags  (prep_flags)
  );

  // shared add-compare for the bit trials
  fpd_step_unit #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_step (
    .prod  (prod),
    .shd   (shd),
    .mag_a (mag_a),
    .sum   (step_sum),
    .take  (step_take)
  );

  // sign restore on the magnitude
  assign signed_q = neg ? -$signed({1'b0, sol}) : $signed({1'b0, sol});
  assign res_free = !res_valid || result.ready;

  assign operands.ready  = (state == ST_IDLE);
  assign result.valid    = res_valid;
  assign result.quotient = res_quotient;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      // output register: loaded from the finish step, cleared when taken
      if (state == ST_FINISH && res_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (operands.valid) begin
            mag_a <= prep_mag_a;
            mag_b <= prep_mag_b;
            if (prep_flags.div_zero) begin
              sol   <= '1;
              neg   <= 1'b0;
              state <= ST_FINISH;
            end else begin
              neg   <= prep_flags.neg;
              state <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          // scale both down until the divisor is at most one
          if (PW'(mag_b) > UNIT) begin
            mag_a <= mag_a >> 1;
            mag_b <= mag_b >> 1;
          end else begin
            prod  <= '0;
            shd   <= PW'(mag_b) << (WORD_BITS - 2);
            bitm  <= (WORD_BITS-1)'(1) << (WORD_BITS - 2);
            sol   <= '0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // one trial bit per cycle, from the top down
          if (step_take) begin
            prod <= step_sum;
            sol  <= sol | bitm;
          end
          shd  <= shd >> 1;
          bitm <= bitm >> 1;
          if (bitm[0]) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (res_free) begin
            res_quotient <= FIELD_BITS'(signed_q);
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
